[src/crs_pkg.sv]
`timescale 1ns / 1ps

package crs_pkg;

  // Reply window: offsets 14 to 49 of the reply report.
  localparam int unsigned REPLY_FIRST = 14;
  localparam int unsigned REPLY_COUNT = 36;
  localparam int unsigned CNT_W       = 6;

  // Flash read length cap and the width of the capped length.
  localparam int unsigned MAX_READ = 29;
  localparam int unsigned REQ_W    = 5;

  // Depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH = 2;

  // Subcommand codes.
  localparam logic [7:0] SUB_DEVICE_INFO = 8'h02;
  localparam logic [7:0] SUB_SET_MODE    = 8'h03;
  localparam logic [7:0] SUB_ELAPSED     = 8'h04;
  localparam logic [7:0] SUB_FLASH_READ  = 8'h10;
  localparam logic [7:0] SUB_LIGHTS      = 8'h30;
  localparam logic [7:0] SUB_IMU         = 8'h40;
  localparam logic [7:0] SUB_VIBRATION   = 8'h48;

  // Report modes that a mode request may select.
  localparam logic [7:0] MODE_STANDARD = 8'h30;
  localparam logic [7:0] MODE_SIMPLE   = 8'h3f;

  // Ack codes.
  localparam logic [7:0] ACK_PLAIN  = 8'h80;
  localparam logic [7:0] ACK_INFO   = 8'h82;
  localparam logic [7:0] ACK_TIME   = 8'h83;
  localparam logic [7:0] ACK_FLASH  = 8'h90;
  localparam logic [7:0] ACK_NONE   = 8'h00;

  // Reply kinds, decided by the front.
  localparam logic [2:0] KIND_GENERIC     = 3'd0;
  localparam logic [2:0] KIND_DEVINFO     = 3'd1;
  localparam logic [2:0] KIND_ELAPSED     = 3'd2;
  localparam logic [2:0] KIND_FLASH       = 3'd3;
  localparam logic [2:0] KIND_FLASH_SHORT = 3'd4;

  // Flash overlay tables.
  localparam logic [2:0] TBL_NONE         = 3'd0;
  localparam logic [2:0] TBL_STICK_CAL    = 3'd1;
  localparam logic [2:0] TBL_STICK_RIGHT  = 3'd2;
  localparam logic [2:0] TBL_MOTION       = 3'd3;
  localparam logic [2:0] TBL_COLORS       = 3'd4;
  localparam logic [2:0] TBL_FACTORY      = 3'd5;
  localparam logic [2:0] TBL_STICK_PARAMS = 3'd6;

  // Flash addresses with known contents.
  localparam logic [31:0] ADDR_STICK_CAL    = 32'h0000_603d;
  localparam logic [31:0] ADDR_STICK_RIGHT  = 32'h0000_6046;
  localparam logic [31:0] ADDR_MOTION       = 32'h0000_6020;
  localparam logic [31:0] ADDR_COLORS       = 32'h0000_6050;
  localparam logic [31:0] ADDR_FACTORY      = 32'h0000_6080;
  localparam logic [31:0] ADDR_STICK_PARAMS = 32'h0000_6098;

  localparam logic [7:0] STICK_CAL [25] = '{
    8'hf0, 8'h07, 8'h7f, 8'hf0, 8'h07, 8'h7f, 8'hf0, 8'h07, 8'h7f,
    8'hf0, 8'h07, 8'h7f, 8'hf0, 8'h07, 8'h7f, 8'hf0, 8'h07, 8'h7f,
    8'h0f, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] FACTORY_PARAMS [24] = '{
    8'h5e, 8'h01, 8'h00, 8'h00, 8'hf1, 8'h0f, 8'h19, 8'hd0,
    8'h4c, 8'hae, 8'h40, 8'he1, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
  localparam logic [7:0] STICK_PARAMS [18] = '{
    8'h19, 8'hd0, 8'h4c, 8'hae, 8'h40, 8'he1, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
  // Offsets 0, 16384 (1 g), 0 and 13371 per axis, little-endian.
  localparam logic [7:0] MOTION_CAL [24] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h40, 8'h00, 8'h40, 8'h00, 8'h40,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3b, 8'h34, 8'h3b, 8'h34, 8'h3b, 8'h34};
  localparam logic [7:0] BODY_COLORS [12] = '{
    8'h32, 8'h32, 8'h32, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
  localparam logic [7:0] ELAPSED_TIME [9] = '{
    8'h00, 8'h6a, 8'h01, 8'hbb, 8'h01, 8'h93, 8'h01, 8'h95, 8'h01};
  localparam logic [7:0] DEVINFO_HEAD [4] = '{8'h03, 8'h48, 8'h03, 8'h02};
  localparam logic [7:0] DEVINFO_TAIL [2] = '{8'h01, 8'h02};

  typedef struct packed {
    logic [7:0]  body_length;
    logic [7:0]  subcommand;
    logic [31:0] param_word;
    logic [7:0]  read_length;
  } in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic [5:0] byte_offset;
    logic       last_byte;
    logic [7:0] mode_now;
    logic [7:0] lights_now;
    logic       imu_on;
    logic       vibration_on;
  } out_t;

  // State after a request, carried with its reply.
  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] lights;
    logic       imu;
    logic       vibration;
  } snap_t;

  // One classified request as handed from front to back.
  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       subcommand;
    logic [31:0]      param_word;
    logic [REQ_W-1:0] req;
    logic [2:0]       tbl;
    snap_t            snap;
  } cmd_t;

  // Overlay byte j of a flash table: bit 8 says the table covers j.
  function automatic logic [8:0] flash_table(input logic [2:0] tbl, input logic [4:0] j);
    logic [8:0] r;
    r = '0;
    unique case (tbl)
      TBL_STICK_CAL: begin
        if (j < 5'd25) r = {1'b1, STICK_CAL[j]};
      end
      TBL_STICK_RIGHT: begin
        if (j < 5'd9) r = {1'b1, STICK_CAL[5'(j + 5'd9)]};
      end
      TBL_MOTION: begin
        if (j < 5'd24) r = {1'b1, MOTION_CAL[j]};
      end
      TBL_COLORS: begin
        if (j < 5'd12) r = {1'b1, BODY_COLORS[j[3:0]]};
      end
      TBL_FACTORY: begin
        if (j < 5'd24) r = {1'b1, FACTORY_PARAMS[j]};
      end
      TBL_STICK_PARAMS: begin
        if (j < 5'd18) r = {1'b1, STICK_PARAMS[j]};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/crs_front.sv]
`timescale 1ns / 1ps

module crs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  crs_pkg::in_t  in_data,
  output logic          in_full,
  input  logic          q_full,
  output logic          q_push,
  output crs_pkg::cmd_t q_cmd
);
  import crs_pkg::*;

  logic [7:0] mode_r, mode_nxt;
  logic [7:0] lights_r, lights_nxt;
  logic       imu_r, imu_nxt;
  logic       vib_r, vib_nxt;
  logic       accept;
  logic       long_enough;
  logic       has_arg;
  logic [7:0] arg;
  logic [REQ_W-1:0] req;

  assign in_full     = q_full;
  assign accept      = in_push && !q_full;
  assign long_enough = in_data.body_length >= 8'd10;
  assign has_arg     = in_data.body_length >= 8'd11;
  assign arg         = in_data.param_word[7:0];
  assign req         = (in_data.read_length > 8'(MAX_READ)) ? REQ_W'(MAX_READ)
                                                            : in_data.read_length[REQ_W-1:0];

  // Requests shorter than ten body bytes are dropped without a reply.
  assign q_push = accept && long_enough;

  always_comb begin
    mode_nxt   = mode_r;
    lights_nxt = lights_r;
    imu_nxt    = imu_r;
    vib_nxt    = vib_r;
    q_cmd.kind       = KIND_GENERIC;
    q_cmd.subcommand = in_data.subcommand;
    q_cmd.param_word = in_data.param_word;
    q_cmd.req        = req;
    q_cmd.tbl        = TBL_NONE;
    unique case (in_data.subcommand)
      SUB_DEVICE_INFO: q_cmd.kind = KIND_DEVINFO;
      SUB_ELAPSED:     q_cmd.kind = KIND_ELAPSED;
      SUB_SET_MODE: begin
        if (has_arg && (arg == MODE_STANDARD || arg == MODE_SIMPLE)) mode_nxt = arg;
      end
      SUB_LIGHTS: begin
        if (has_arg) lights_nxt = arg;
      end
      SUB_IMU: begin
        if (has_arg) imu_nxt = arg != 8'd0;
      end
      SUB_VIBRATION: begin
        if (has_arg) vib_nxt = arg != 8'd0;
      end
      SUB_FLASH_READ: begin
        if (in_data.body_length >= 8'd15) begin
          q_cmd.kind = KIND_FLASH;
        end else begin
          q_cmd.kind = KIND_FLASH_SHORT;
        end
      end
      default: q_cmd.kind = KIND_GENERIC;
    endcase
    unique case (in_data.param_word)
      ADDR_STICK_CAL:    q_cmd.tbl = TBL_STICK_CAL;
      ADDR_STICK_RIGHT:  q_cmd.tbl = TBL_STICK_RIGHT;
      ADDR_MOTION:       q_cmd.tbl = TBL_MOTION;
      ADDR_COLORS:       q_cmd.tbl = (req >= REQ_W'(12)) ? TBL_COLORS : TBL_NONE;
      ADDR_FACTORY:      q_cmd.tbl = TBL_FACTORY;
      ADDR_STICK_PARAMS: q_cmd.tbl = TBL_STICK_PARAMS;
      default:           q_cmd.tbl = TBL_NONE;
    endcase
    q_cmd.snap.mode      = mode_nxt;
    q_cmd.snap.lights    = lights_nxt;
    q_cmd.snap.imu       = imu_nxt;
    q_cmd.snap.vibration = vib_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STANDARD;
      lights_r <= '0;
      imu_r    <= 1'b0;
      vib_r    <= 1'b0;
    end else if (q_push) begin
      mode_r   <= mode_nxt;
      lights_r <= lights_nxt;
      imu_r    <= imu_nxt;
      vib_r    <= vib_nxt;
    end
  end

endmodule

[src/crs_cmd_queue.sv]
`timescale 1ns / 1ps

module crs_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output crs_pkg::cmd_t head_cmd
);
  import crs_pkg::*;

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(CMD_DEPTH + 1);

  cmd_t              slot_r [CMD_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = count_r == CNT_QW'(CMD_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/crs_back.sv]
`timescale 1ns / 1ps

module crs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [47:0]   dev_addr,
  input  logic          head_valid,
  input  crs_pkg::cmd_t head_cmd,
  output logic          q_pop,
  output crs_pkg::out_t out_data,
  output logic          out_empty,
  input  logic          out_pop
);
  import crs_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             load;
  logic             last;
  logic [5:0]       off;
  logic [7:0]       byte_v;
  logic [2:0]       ai;
  logic [1:0]       pi;
  logic [3:0]       ei;
  logic [4:0]       fj;
  logic [8:0]       tb;

  assign last      = cnt_r == CNT_W'(REPLY_COUNT - 1);
  assign load      = head_valid && (!out_valid_r || out_pop);
  assign q_pop     = load && last;
  assign off       = 6'(REPLY_FIRST) + cnt_r;
  assign out_data  = out_r;
  assign out_empty = !out_valid_r;

  always_comb begin
    ai = 3'(off - 6'd20);
    pi = 2'(off - 6'd16);
    ei = 4'(off - 6'd16);
    fj = 5'(off - 6'd21);
    tb = flash_table(head_cmd.tbl, fj);
    byte_v = '0;
    unique case (head_cmd.kind)
      KIND_GENERIC: begin
        if (off == 6'd14) byte_v = ACK_PLAIN;
        else if (off == 6'd15) byte_v = head_cmd.subcommand;
      end
      KIND_DEVINFO: begin
        if (off == 6'd14) byte_v = ACK_INFO;
        else if (off == 6'd15) byte_v = head_cmd.subcommand;
        else if (off <= 6'd19) byte_v = DEVINFO_HEAD[pi];
        else if (off <= 6'd25) byte_v = dev_addr[{ai, 3'b000} +: 8];
        else if (off <= 6'd27) byte_v = DEVINFO_TAIL[off[0]];
      end
      KIND_ELAPSED: begin
        if (off == 6'd14) byte_v = ACK_TIME;
        else if (off == 6'd15) byte_v = head_cmd.subcommand;
        else if (off <= 6'd24) byte_v = ELAPSED_TIME[ei];
      end
      KIND_FLASH: begin
        if (off == 6'd14) byte_v = ACK_FLASH;
        else if (off == 6'd15) byte_v = SUB_FLASH_READ;
        else if (off <= 6'd19) byte_v = head_cmd.param_word[{pi, 3'b000} +: 8];
        else if (off == 6'd20) byte_v = 8'(head_cmd.req);
        else if (fj < head_cmd.req) byte_v = tb[8] ? tb[7:0] : 8'hff;
      end
      KIND_FLASH_SHORT: begin
        if (off == 6'd14) byte_v = ACK_NONE;
        else if (off == 6'd15) byte_v = SUB_FLASH_READ;
      end
      default: byte_v = '0;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load) begin
      cnt_nxt               = last ? '0 : cnt_r + 1'b1;
      out_valid_nxt         = 1'b1;
      out_nxt.reply_byte    = byte_v;
      out_nxt.byte_offset   = off;
      out_nxt.last_byte     = last;
      out_nxt.mode_now      = head_cmd.snap.mode;
      out_nxt.lights_now    = head_cmd.snap.lights;
      out_nxt.imu_on        = head_cmd.snap.imu;
      out_nxt.vibration_on  = head_cmd.snap.vibration;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

[src/controller_subcommand_responder.sv]
`timescale 1ns / 1ps

// Controller subcommand responder.
// Input channel: a request transaction (body length, subcommand, parameter word,
// read length) is taken when in_push is high and in_full is low. Requests with
// fewer than ten body bytes are consumed silently and produce no reply.
// Result channel: every other request produces 36 reply bytes, offsets 14 to 49
// in order, the last one flagged by last_byte. A byte is presented while
// out_empty is low and is taken when out_pop is high. Each byte also carries the
// kept mode, lights, motion and vibration state as left by its request.
// An accepted request enters a two-entry command queue between the classifier
// and the reply generator, which then registers the reply bytes in the output
// register, one reply byte per cycle while the receiver takes them. The queue
// lets further requests be accepted while a reply is still streaming. If the
// receiver stalls, the current byte holds in the output register and in_full
// rises once the queue is taken up.
// Configuration: cfg_data, the six-byte device address, is written when
// cfg_valid and cfg_ready are high; cfg_ready is always high. Write it only
// while no reply is pending.
// Reset (synchronous, rst_n low) clears the address and the queue, sets the
// report mode to 0x30 and clears lights, motion and vibration.
module controller_subcommand_responder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  crs_pkg::in_t  in_data,
  output logic          in_full,
  output crs_pkg::out_t out_data,
  output logic          out_empty,
  input  logic          out_pop,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [47:0]   cfg_data
);
  import crs_pkg::*;

  logic [47:0] dev_addr_r;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        head_valid;
  cmd_t        push_cmd;
  cmd_t        head_cmd;

  // The address register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  // Front: takes requests, updates the kept state and classifies the reply.
  crs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  // Short queue of classified commands.
  crs_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: streams the 36 reply bytes of the command at the head of the queue.
  crs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dev_addr   (dev_addr_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .q_pop      (q_pop),
    .out_data   (out_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

endmodule
